FILE: rtl/kdeg_pkg.sv
`timescale 1ns / 1ps

package kdeg_pkg;

	localparam int unsigned MAX_KEYS  = 8;
	localparam int unsigned CNT_W     = 4;
	localparam int unsigned IDX_W     = 3;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CNT_W-1:0] MAKE_COUNT_RST  = 4'd5;
	localparam logic [CNT_W-1:0] BREAK_COUNT_RST = 4'd5;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAKE_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BREAK_COUNT = 2'd1;

	typedef enum logic [1:0] {
		DB_IDLE_UP   = 2'd0,
		DB_WAIT_DOWN = 2'd1,
		DB_HELD_DOWN = 2'd2,
		DB_WAIT_UP   = 2'd3
	} db_state_t;

	// Events caused by one sample: one bit per key, plus make/break per key
	typedef struct packed {
		logic [MAX_KEYS-1:0] fire;
		logic [MAX_KEYS-1:0] make;
	} evt_set_t;

endpackage

FILE: rtl/kdeg_sample_if.sv
`timescale 1ns / 1ps

interface kdeg_sample_if;
	logic       valid;
	logic       ready;
	logic [7:0] key_levels;

	modport source (output valid, output key_levels, input ready);
	modport sink   (input valid, input key_levels, output ready);
endinterface

FILE: rtl/kdeg_event_if.sv
`timescale 1ns / 1ps

interface kdeg_event_if;
	logic       valid;
	logic       ready;
	logic [2:0] key_index;
	logic       is_make;
	logic       last;

	modport source (output valid, output key_index, output is_make, output last, input ready);
	modport sink   (input valid, input key_index, input is_make, input last, output ready);
endinterface

FILE: rtl/kdeg_debounce.sv
`timescale 1ns / 1ps

module kdeg_debounce #(
	parameter int unsigned NUM_KEYS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          take,
	input  logic [kdeg_pkg::MAX_KEYS-1:0] key_levels,
	input  logic [kdeg_pkg::CNT_W-1:0]    make_count,
	input  logic [kdeg_pkg::CNT_W-1:0]    break_count,
	output kdeg_pkg::evt_set_t            evts
);

	kdeg_pkg::db_state_t              state_q [NUM_KEYS];
	logic [kdeg_pkg::CNT_W-1:0]       cnt_q   [NUM_KEYS];
	kdeg_pkg::db_state_t              state_d [NUM_KEYS];
	logic [kdeg_pkg::CNT_W-1:0]       cnt_d   [NUM_KEYS];

	always_comb begin
		evts = '0;
		for (int k = 0; k < NUM_KEYS; k++) begin
			state_d[k] = state_q[k];
			cnt_d[k]   = cnt_q[k];
			case (state_q[k])
				kdeg_pkg::DB_IDLE_UP: begin
					if (key_levels[k]) begin
						state_d[k] = kdeg_pkg::DB_WAIT_DOWN;
						cnt_d[k]   = make_count;
					end
				end
				kdeg_pkg::DB_WAIT_DOWN: begin
					if (!key_levels[k]) begin
						state_d[k] = kdeg_pkg::DB_IDLE_UP;
						cnt_d[k]   = '0;
					end else if (cnt_q[k] <= 4'd1) begin
						// count of zero behaves like one
						state_d[k]   = kdeg_pkg::DB_HELD_DOWN;
						cnt_d[k]     = '0;
						evts.fire[k] = 1'b1;
						evts.make[k] = 1'b1;
					end else begin
						cnt_d[k] = cnt_q[k] - 4'd1;
					end
				end
				kdeg_pkg::DB_HELD_DOWN: begin
					if (!key_levels[k]) begin
						state_d[k] = kdeg_pkg::DB_WAIT_UP;
						cnt_d[k]   = break_count;
					end
				end
				kdeg_pkg::DB_WAIT_UP: begin
					if (key_levels[k]) begin
						state_d[k] = kdeg_pkg::DB_HELD_DOWN;
						cnt_d[k]   = '0;
					end else if (cnt_q[k] <= 4'd1) begin
						state_d[k]   = kdeg_pkg::DB_IDLE_UP;
						cnt_d[k]     = '0;
						evts.fire[k] = 1'b1;
					end else begin
						cnt_d[k] = cnt_q[k] - 4'd1;
					end
				end
				default: begin
					state_d[k] = kdeg_pkg::DB_IDLE_UP;
					cnt_d[k]   = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_KEYS; k++) begin
				state_q[k] <= kdeg_pkg::DB_IDLE_UP;
				cnt_q[k]   <= '0;
			end
		end else if (take) begin
			for (int k = 0; k < NUM_KEYS; k++) begin
				state_q[k] <= state_d[k];
				cnt_q[k]   <= cnt_d[k];
			end
		end
	end

endmodule

FILE: rtl/kdeg_event_emit.sv
`timescale 1ns / 1ps

module kdeg_event_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  kdeg_pkg::evt_set_t  evts,
	output logic                can_take,
	kdeg_event_if.source        evt
);

	logic [kdeg_pkg::MAX_KEYS-1:0] mask_q;
	logic [kdeg_pkg::MAX_KEYS-1:0] make_q;
	logic [kdeg_pkg::MAX_KEYS-1:0] rest;
	logic [kdeg_pkg::IDX_W-1:0]    pick;
	logic                          adv;

	logic                          valid_q;
	logic [kdeg_pkg::IDX_W-1:0]    idx_q;
	logic                          make_bit_q;
	logic                          last_q;

	// lowest pending key goes first
	always_comb begin
		pick = '0;
		for (int k = kdeg_pkg::MAX_KEYS - 1; k >= 0; k--) begin
			if (mask_q[k]) begin
				pick = kdeg_pkg::IDX_W'(k);
			end
		end
	end

	assign rest     = mask_q & (mask_q - 1'b1);
	assign adv      = (mask_q != '0) && (!valid_q || evt.ready);
	assign can_take = (mask_q == '0) || (adv && (rest == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load) begin
			mask_q <= evts.fire;
		end else if (adv) begin
			mask_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			make_q <= evts.make;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= 1'b1;
		end else if (evt.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_q      <= pick;
			make_bit_q <= make_q[pick];
			last_q     <= (rest == '0);
		end
	end

	assign evt.valid     = valid_q;
	assign evt.key_index = idx_q;
	assign evt.is_make   = make_bit_q;
	assign evt.last      = last_q;

endmodule

FILE: rtl/key_debounce_event_gen.sv
`timescale 1ns / 1ps

// Key debouncer with make/break events. Each sample transaction carries the
// levels of up to eight keys (bit k = key k, 1 pressed). Every key runs a
// four-state debouncer (stable released, pending press, stable pressed,
// pending release) with a 4-bit countdown loaded from make_count or
// break_count; a pending key falls back at once if its level reverts, and a
// count of zero acts as one. Keys at or above NUM_KEYS are ignored. A key
// that turns stable yields one event transaction (key_index, is_make), in
// ascending key order, with last set on the final event of that sample; a
// sample that settles nothing yields no event. Timing: a sample updates all
// debouncers in the cycle it is accepted; its events then leave through a
// registered output at one per cycle while evt.ready stays high; the next
// sample is taken in the cycle the previous sample's final event enters the
// output register. Samples with no events are taken every cycle while no
// events wait to be serialized. Configuration writes (cfg_we, cfg_index,
// cfg_wdata) take effect on the next clock; only indexes 0 (make_count) and
// 1 (break_count) exist, and only the low four bits are kept. Write them
// while the block is idle.

module key_debounce_event_gen #(
	parameter int unsigned NUM_KEYS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	kdeg_sample_if.sink                    sample,
	kdeg_event_if.source                   evt,
	input  logic                           cfg_we,
	input  logic [kdeg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [kdeg_pkg::CNT_W-1:0]     cfg_wdata
);

	logic [kdeg_pkg::CNT_W-1:0] make_count_q;
	logic [kdeg_pkg::CNT_W-1:0] break_count_q;
	logic                       can_take;
	logic                       take;
	kdeg_pkg::evt_set_t         evts;

	// Config registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			make_count_q  <= kdeg_pkg::MAKE_COUNT_RST;
			break_count_q <= kdeg_pkg::BREAK_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				kdeg_pkg::CFG_MAKE_COUNT:  make_count_q  <= cfg_wdata;
				kdeg_pkg::CFG_BREAK_COUNT: break_count_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Sample accepted only when the event queue can hold its results
	assign sample.ready = can_take;
	assign take         = sample.valid && can_take;

	kdeg_debounce #(
		.NUM_KEYS (NUM_KEYS)
	) u_debounce (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.key_levels  (sample.key_levels),
		.make_count  (make_count_q),
		.break_count (break_count_q),
		.evts        (evts)
	);

	// Serializes the event set of one sample, lowest key first
	kdeg_event_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (take),
		.evts     (evts),
		.can_take (can_take),
		.evt      (evt)
	);

endmodule

FILE: tb/sv/key_debounce_event_gen_test.sv
`timescale 1ns / 1ps

module key_debounce_event_gen_test;

	// Quiet cycles (no transaction on either channel) before the run is abandoned.
	// Longest legit quiet stretch is a long idle gap or a config pause, well under this.
	localparam int unsigned QUIET_LIMIT = 2000;
	// Settle time after the last expected event before touching config or ending.
	localparam int unsigned SETTLE_CYCLES = 12;

	// One key event as it should leave the block
	typedef struct packed {
		logic [kdeg_pkg::IDX_W-1:0] key_index;
		logic                       is_make;
		logic                       last;
	} key_event_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [kdeg_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [kdeg_pkg::CNT_W-1:0] cfg_wdata;

	kdeg_sample_if sample_ch ();
	kdeg_event_if  event_ch ();

	key_debounce_event_gen dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.evt       (event_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Scan samples still to be sent, and key events still to be seen
	logic [7:0] scan_q[$];
	key_event_t pending_events[$];

	// Own copy of the per-key debouncers and the two count registers
	kdeg_pkg::db_state_t key_st[kdeg_pkg::MAX_KEYS];
	logic [kdeg_pkg::CNT_W-1:0] key_cnt[kdeg_pkg::MAX_KEYS];
	logic [kdeg_pkg::CNT_W-1:0] make_len;
	logic [kdeg_pkg::CNT_W-1:0] break_len;

	// Idle knobs, changed per phase by the stimulus process
	bit send_idle;
	bit rcv_idle;

	int unsigned send_gap;
	int unsigned rcv_gap;
	int unsigned quiet_cycles;
	int unsigned n_err;
	int unsigned n_samples;
	int unsigned n_events;
	int unsigned n_settings;
	logic [7:0] last_levels;
	key_event_t got;
	key_event_t want;

	always #5 clk = ~clk;

	// Mostly back-to-back, some short gaps, a few long ones
	function automatic int unsigned idle_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 25);
	endfunction

	// Steps every debouncer with one sample and queues the events it settles,
	// in ascending key order, last flag on the final one.
	function automatic void debounce_sample(input logic [7:0] levels);
		int unsigned n_before;
		logic down;
		key_event_t ev;
		n_before = pending_events.size();
		for (int k = 0; k < kdeg_pkg::MAX_KEYS; k++) begin
			down = levels[k];
			ev.key_index = kdeg_pkg::IDX_W'(k);
			ev.last = 1'b0;
			case (key_st[k])
				kdeg_pkg::DB_IDLE_UP: begin
					if (down) begin
						key_st[k] = kdeg_pkg::DB_WAIT_DOWN;
						key_cnt[k] = make_len;
					end
				end
				kdeg_pkg::DB_WAIT_DOWN: begin
					if (!down) begin
						key_st[k] = kdeg_pkg::DB_IDLE_UP;
						key_cnt[k] = '0;
					end else if (key_cnt[k] <= 1) begin
						// zero count behaves like one: settles on the next sample
						key_st[k] = kdeg_pkg::DB_HELD_DOWN;
						key_cnt[k] = '0;
						ev.is_make = 1'b1;
						pending_events.push_back(ev);
					end else begin
						key_cnt[k] = key_cnt[k] - 1'b1;
					end
				end
				kdeg_pkg::DB_HELD_DOWN: begin
					if (!down) begin
						key_st[k] = kdeg_pkg::DB_WAIT_UP;
						key_cnt[k] = break_len;
					end
				end
				default: begin
					if (down) begin
						// bounce during release: back to held, no event
						key_st[k] = kdeg_pkg::DB_HELD_DOWN;
						key_cnt[k] = '0;
					end else if (key_cnt[k] <= 1) begin
						key_st[k] = kdeg_pkg::DB_IDLE_UP;
						key_cnt[k] = '0;
						ev.is_make = 1'b0;
						pending_events.push_back(ev);
					end else begin
						key_cnt[k] = key_cnt[k] - 1'b1;
					end
				end
			endcase
		end
		if (pending_events.size() > n_before)
			pending_events[$].last = 1'b1;
	endfunction

	// Register write; the block is idle whenever this is called
	task automatic write_reg(input logic [kdeg_pkg::CFG_IDX_W-1:0] idx,
			input logic [kdeg_pkg::CNT_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		// indexes other than the two counts are ignored by the block
		if (idx == kdeg_pkg::CFG_MAKE_COUNT)
			make_len = val;
		else if (idx == kdeg_pkg::CFG_BREAK_COUNT)
			break_len = val;
	endtask

	task automatic set_counts(input logic [kdeg_pkg::CNT_W-1:0] mk,
			input logic [kdeg_pkg::CNT_W-1:0] brk);
		write_reg(kdeg_pkg::CFG_MAKE_COUNT, mk);
		write_reg(kdeg_pkg::CFG_BREAK_COUNT, brk);
		n_settings++;
	endtask

	// Hold off until every queued sample is taken and every event has come out,
	// then give the output register time to flush anything unexpected.
	// Checked mid-cycle so the driver's and monitor's updates have landed.
	task automatic drain();
		do
			@(negedge clk);
		while (scan_q.size() != 0 || sample_ch.valid || pending_events.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Random walk over key levels: long holds so keys actually settle, single-key
	// toggles (bounces when they flip back soon), and some multi-key noise.
	task automatic random_phase(input int unsigned n, input int unsigned hold_pct);
		logic [7:0] lv;
		int unsigned r;
		lv = last_levels;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r >= hold_pct) begin
				if (r < hold_pct + (100 - hold_pct) * 2 / 3)
					lv[$urandom_range(0, kdeg_pkg::MAX_KEYS - 1)] ^= 1'b1;
				else if (r < 97)
					lv ^= 8'($urandom);
				else
					lv = 8'($urandom);
			end
			scan_q.push_back(lv);
		end
		last_levels = lv;
	endtask

	// Sample driver: new transaction whenever the slot is free and no gap is pending
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_ch.valid && sample_ch.ready) begin
				debounce_sample(sample_ch.key_levels);
				n_samples++;
			end
			if (!sample_ch.valid || sample_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					sample_ch.valid <= 1'b0;
				end else if (scan_q.size() > 0) begin
					sample_ch.valid <= 1'b1;
					sample_ch.key_levels <= scan_q.pop_front();
					send_gap = send_idle ? idle_gap() : 0;
				end else begin
					sample_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Event monitor with random backpressure
	always @(posedge clk) begin
		if (arst_n) begin
			if (event_ch.valid && event_ch.ready) begin
				n_events++;
				got.key_index = event_ch.key_index;
				got.is_make = event_ch.is_make;
				got.last = event_ch.last;
				if (pending_events.size() == 0) begin
					n_err++;
					$error("unexpected event: key_index %0d is_make %0d last %0d",
						got.key_index, got.is_make, got.last);
				end else begin
					want = pending_events.pop_front();
					if (got.key_index !== want.key_index) begin
						n_err++;
						$error("key_index mismatch: expected %0d, got %0d",
							want.key_index, got.key_index);
					end
					if (got.is_make !== want.is_make) begin
						n_err++;
						$error("is_make mismatch: expected %0d, got %0d",
							want.is_make, got.is_make);
					end
					if (got.last !== want.last) begin
						n_err++;
						$error("last mismatch: expected %0d, got %0d", want.last, got.last);
					end
				end
				rcv_gap = rcv_idle ? idle_gap() : 0;
			end
			if (rcv_gap > 0) begin
				event_ch.ready <= 1'b0;
				rcv_gap--;
			end else begin
				event_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: a hang shows up as a long run of cycles with no transaction
	always @(posedge clk) begin
		if (!arst_n || (sample_ch.valid && sample_ch.ready)
				|| (event_ch.valid && event_ch.ready) || cfg_we)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: %0d events still outstanding", pending_events.size());
			$display("key_debounce_event_gen test failed");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = kdeg_pkg::CFG_MAKE_COUNT;
		cfg_wdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.key_levels = '0;
		event_ch.ready = 1'b0;
		for (int k = 0; k < kdeg_pkg::MAX_KEYS; k++) begin
			key_st[k] = kdeg_pkg::DB_IDLE_UP;
			key_cnt[k] = '0;
		end
		make_len = kdeg_pkg::MAKE_COUNT_RST;
		break_len = kdeg_pkg::BREAK_COUNT_RST;
		send_idle = 1'b1;
		rcv_idle = 1'b1;
		send_gap = 0;
		rcv_gap = 0;
		quiet_cycles = 0;
		n_err = 0;
		n_samples = 0;
		n_events = 0;
		n_settings = 1;
		last_levels = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed, reset counts of five: all keys make together (eight events,
		// last on key 7), a release that bounces back, then half the keys break.
		scan_q.push_back(8'h00);
		repeat (6) scan_q.push_back(8'hFF);
		scan_q.push_back(8'h00);
		scan_q.push_back(8'hFF);
		repeat (6) scan_q.push_back(8'h0F);
		// press on key 4 that bounces off before settling
		scan_q.push_back(8'h1F);
		scan_q.push_back(8'h0F);
		drain();

		// Zero counts act as one; writes to unused indexes must change nothing
		set_counts(4'd0, 4'd0);
		write_reg(kdeg_pkg::CFG_IDX_W'(2), 4'hF);
		write_reg(kdeg_pkg::CFG_IDX_W'(3), 4'hA);
		scan_q.push_back(8'hAA);
		scan_q.push_back(8'hAA);
		scan_q.push_back(8'h55);
		scan_q.push_back(8'h55);
		scan_q.push_back(8'hFF);
		scan_q.push_back(8'h00);
		scan_q.push_back(8'h00);
		scan_q.push_back(8'h80);
		drain();
		last_levels = 8'h80;

		// Longest debounce both ways: needs long holds to settle anything
		set_counts(4'd15, 4'd15);
		random_phase(36, 88);
		drain();

		// Shortest counts, no idling on either side: dense event bursts
		send_idle = 1'b0;
		rcv_idle = 1'b0;
		set_counts(4'd1, 4'd1);
		random_phase(40, 40);
		drain();

		// Asymmetric counts, only the event side stalls
		rcv_idle = 1'b1;
		set_counts(4'd3, 4'd9);
		random_phase(40, 65);
		drain();

		// Random counts, both sides idle
		send_idle = 1'b1;
		set_counts(kdeg_pkg::CNT_W'($urandom_range(0, 15)),
			kdeg_pkg::CNT_W'($urandom_range(0, 15)));
		random_phase(40, 70);
		drain();

		// Slow make, instant break, only the sample side idles
		rcv_idle = 1'b0;
		set_counts(4'd15, 4'd1);
		random_phase(40, 80);
		drain();

		if (pending_events.size() != 0) begin
			n_err++;
			$error("pending events: expected %0d, actual %0d", 0, pending_events.size());
		end

		$display("Sent %0d scan samples under %0d count settings; checked %0d key events.",
			n_samples, n_settings, n_events);
		if (n_err == 0)
			$display("key_debounce_event_gen test passed");
		else
			$display("key_debounce_event_gen test failed");
		$finish;
	end

endmodule
